// File: hw/rtl/minimal_mask_set_table_macros.svh
// ---------------------------------------------------------------------------
// Minimal mask set table assertion macros
// Shared concurrent assertion forms for the mask table RTL.
// ---------------------------------------------------------------------------
`ifndef MINIMAL_MASK_SET_TABLE_MACROS_SVH
`define MINIMAL_MASK_SET_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMST_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mask table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MMST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mask table assertion failed");

`endif

// File: hw/rtl/mmst_pkg.sv
// ---------------------------------------------------------------------------
// Minimal mask set table package
// Sizes, request and response types, codes and controller interface types.
// ---------------------------------------------------------------------------
package mmst_pkg;

   localparam int MAX_ENTRIES = 256;
   localparam int ADDR_W      = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = ADDR_W + 1;
   // Common width for comparing the 8-bit read index with the fill count.
   localparam int IDX_CMP_W   = (CNT_W > 9) ? CNT_W : 9;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_CLEAR  = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      RS_INSERTED = 3'd0,
      RS_COVERED  = 3'd1,
      RS_GATED    = 3'd2,
      RS_FULL     = 3'd3,
      RS_CLEARED  = 3'd4,
      RS_READ_OK  = 3'd5,
      RS_READ_OOR = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] trade_mask;
      logic [6:0]  cell_count;
      logic [7:0]  read_index;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] entry_mask;
      logic        entry_active;
      logic [6:0]  entry_cells;
      logic [8:0]  entries_used;
   } rsp_payload_type;

   typedef struct packed {
      logic [63:0] mask;
      logic        active;
      logic [6:0]  cells;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic       capture;
      logic       scan_start;
      logic       scan_run;
      logic       rd_request;
      logic       append;
      logic       clear;
      logic       load_rsp;
      status_type status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       gated;
      logic       read_ok;
      logic       scan_hit;
      logic       scan_done;
      logic       table_full;
   } stat_type;

endpackage

// File: hw/rtl/mmst_ram.sv
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module mmst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/mmst_dpath.sv
// ---------------------------------------------------------------------------
// Mask table datapath
// Entry memory, fill count, scan pipeline, subset compare and response.
// ---------------------------------------------------------------------------
module mmst_dpath (
   input  logic                     clock,
   input  logic                     reset,
   input  mmst_pkg::req_payload_type req_payload,
   input  logic                     csr_wr_en,
   input  logic [6:0]               csr_wr_data,
   input  mmst_pkg::cmd_type        cmd,
   output mmst_pkg::stat_type       stat,
   output mmst_pkg::rsp_payload_type rsp_payload
);
   import mmst_pkg::*;

   req_payload_type req_ff;
   rsp_payload_type rsp_ff, rsp_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  scan_addr_ff, scan_addr_in;
   logic              cmp_valid_ff, cmp_valid_in;
   logic [ADDR_W-1:0] cmp_addr_ff;
   logic [6:0]        max_cells_ff;

   logic              scan_issue;
   logic              is_subset;
   logic              is_superset;
   logic              mark_write;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   entry_type         ram_wr_entry;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type         rd_entry;

   mmst_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_entry),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = entry_type'(ram_rd_data);

   // Scan read stage: one stored entry is fetched per cycle.
   assign scan_issue  = cmd.scan_run && (scan_addr_ff < used_ff);
   assign ram_rd_en   = cmd.rd_request || scan_issue;
   assign ram_rd_addr = cmd.rd_request ? ADDR_W'(req_payload.read_index)
                                       : scan_addr_ff[ADDR_W-1:0];

   // Compare stage. Equal masks count as a subset, which wins over marking.
   assign is_subset   = (req_ff.trade_mask & rd_entry.mask) == rd_entry.mask;
   assign is_superset = (req_ff.trade_mask & rd_entry.mask) == req_ff.trade_mask;
   assign mark_write  = cmd.scan_run && cmp_valid_ff && is_superset && !is_subset;

   always_comb begin
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cmp_addr_ff;
      ram_wr_entry = rd_entry;
      if (cmd.append) begin
         ram_wr_en           = 1'b1;
         ram_wr_addr         = used_ff[ADDR_W-1:0];
         ram_wr_entry.mask   = req_ff.trade_mask;
         ram_wr_entry.active = 1'b1;
         ram_wr_entry.cells  = req_ff.cell_count;
      end else if (mark_write) begin
         ram_wr_en           = 1'b1;
         ram_wr_entry.active = 1'b0;
      end
   end

   always_comb begin
      scan_addr_in = scan_addr_ff;
      cmp_valid_in = 1'b0;
      if (cmd.scan_start) begin
         scan_addr_in = '0;
      end else if (cmd.scan_run) begin
         cmp_valid_in = scan_issue;
         if (scan_issue) begin
            scan_addr_in = scan_addr_ff + CNT_W'(1);
         end
      end
   end

   always_comb begin
      used_in = used_ff;
      if (cmd.clear) begin
         used_in = '0;
      end else if (cmd.append) begin
         used_in = used_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in              = '0;
      rsp_in.status       = cmd.status;
      rsp_in.entries_used = 9'(used_in);
      if (cmd.status == RS_READ_OK) begin
         rsp_in.entry_mask   = rd_entry.mask;
         rsp_in.entry_active = rd_entry.active;
         rsp_in.entry_cells  = rd_entry.cells;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         scan_addr_ff <= '0;
         cmp_valid_ff <= 1'b0;
         max_cells_ff <= 7'd64;
      end else begin
         used_ff      <= used_in;
         scan_addr_ff <= scan_addr_in;
         cmp_valid_ff <= cmp_valid_in;
         if (csr_wr_en) begin
            max_cells_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_addr_ff <= scan_addr_ff[ADDR_W-1:0];
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign stat.op         = req_payload.req_type;
   assign stat.gated      = (req_payload.trade_mask == 64'd0) ||
                            (req_payload.cell_count > max_cells_ff);
   assign stat.read_ok    = IDX_CMP_W'(req_payload.read_index) < IDX_CMP_W'(used_ff);
   assign stat.scan_hit   = cmp_valid_ff && is_subset;
   assign stat.scan_done  = !cmp_valid_ff && !(scan_addr_ff < used_ff);
   assign stat.table_full = used_ff >= CNT_W'(MAX_ENTRIES);

   assign rsp_payload = rsp_ff;

endmodule

// File: hw/rtl/mmst_ctrl.sv
// ---------------------------------------------------------------------------
// Mask table controller
// Sequences insert scans, clears and reads, and owns the response valid.
// ---------------------------------------------------------------------------
module mmst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  mmst_pkg::stat_type stat,
   output mmst_pkg::cmd_type  cmd
);
   import mmst_pkg::*;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_FINISH;
               case (op_type'(stat.op))
                  OP_INSERT: begin
                     if (stat.gated) begin
                        code_in = RS_GATED;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  OP_CLEAR: code_in = RS_CLEARED;
                  OP_READ:  code_in = stat.read_ok ? RS_READ_OK : RS_READ_OOR;
                  default:  code_in = RS_GATED;
               endcase
            end
         end
         ST_SCAN: begin
            if (stat.scan_hit) begin
               code_in  = RS_COVERED;
               state_in = ST_FINISH;
            end else if (stat.scan_done) begin
               code_in  = stat.table_full ? RS_FULL : RS_INSERTED;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == ST_FINISH && slot_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.status = code_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture    = accept;
            cmd.scan_start = accept;
            cmd.rd_request = accept && (op_type'(stat.op) == OP_READ) && stat.read_ok;
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
         end
         ST_FINISH: begin
            cmd.load_rsp = slot_free;
            cmd.append   = slot_free && (code_ff == RS_INSERTED);
            cmd.clear    = slot_free && (code_ff == RS_CLEARED);
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         code_ff      <= RS_GATED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         code_ff      <= code_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/minimal_mask_set_table.sv
// ---------------------------------------------------------------------------
// Minimal mask set table
// Table of cell masks kept subset-minimal, with insert, clear and read.
//
//   Channel   Direction  Handshake              Payload
//   req       in         req_valid/req_ready    req_payload (req_payload_type)
//   rsp       out        rsp_valid/rsp_ready    rsp_payload (rsp_payload_type)
//   csr       in         csr_wr_en              csr_wr_data (max_cells)
//
// An insert holds the block through its scan: the scan reads one entry per
// cycle from the single entry RAM read port, with one compare stage behind it,
// and a subset hit ends it early. One request is worked on at a time; a new one
// is taken while the previous response waits in its output register, and
// finishes only once that register is free.
// Reset empties the table at once; the entry RAM needs no clearing pass.
// ---------------------------------------------------------------------------
`include "minimal_mask_set_table_macros.svh"

module minimal_mask_set_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mmst_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mmst_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_wr_en,
   input  logic [6:0]                csr_wr_data
);
   import mmst_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   mmst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mmst_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_payload (rsp_payload)
   );

   // A full table must never be appended to.
   `MMST_ASSERT_SAME(a_no_append_full, clock, reset, cmd.append, !stat.table_full)

   // Only a successful read carries entry data.
   `MMST_ASSERT_SAME(a_entry_zero, clock, reset,
      rsp_valid && (rsp_payload.status != RS_READ_OK),
      (rsp_payload.entry_mask == 64'd0) && !rsp_payload.entry_active &&
      (rsp_payload.entry_cells == 7'd0))

   // After a request is taken, the block is busy in the next cycle.
   `MMST_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule
